[rtl/rmo_pkg.sv]
// ----------------------------------------------------------------------------
// rmo_pkg
// Shared types and constants of the rotation matrix orthonormalizer.
// ----------------------------------------------------------------------------
package rmo_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRAC_W          = COMPONENT_WIDTH - 2;
    localparam int CROSS_W         = 2 * COMPONENT_WIDTH + 1;
    localparam int MAG_W           = 32;
    localparam int SUM_W           = 64;
    localparam int ISQRT_STEPS     = 32;
    localparam int NORM_LAT        = 41 + FRAC_W;
    localparam int CROSS_LAT       = 2;
    localparam int LATENCY         = 3 * NORM_LAT + 2 * CROSS_LAT + 1;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t left_x;
        comp_t left_y;
        comp_t left_z;
        comp_t up_x;
        comp_t up_y;
        comp_t up_z;
    } item_t;

    typedef struct packed {
        comp_t new_left_x;
        comp_t new_left_y;
        comp_t new_left_z;
        comp_t new_up_x;
        comp_t new_up_y;
        comp_t new_up_z;
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        logic  degenerate;
    } result_t;

endpackage

[rtl/rmo_cross.sv]
// ----------------------------------------------------------------------------
// rmo_cross
// Two-stage pipelined cross product of two signed 3-vectors.
// ----------------------------------------------------------------------------
module rmo_cross #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int SW = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [2:0][AW-1:0]       in_a,
    input  logic [2:0][BW-1:0]       in_b,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [2:0][AW+BW:0]      out_vec,
    output logic [SW-1:0]            out_side
);

    localparam int PW = AW + BW;

    logic                 p_valid_reg;
    logic signed [PW-1:0] pr_reg [6];
    logic signed [PW-1:0] pr_next [6];
    logic [SW-1:0]        p_side_reg;
    logic [2:0][PW:0]     c_next;
    logic                 c_valid_reg;
    logic [2:0][PW:0]     c_reg;
    logic [SW-1:0]        c_side_reg;

    always_comb
    begin
        pr_next[0] = $signed(in_a[1]) * $signed(in_b[2]);
        pr_next[1] = $signed(in_a[2]) * $signed(in_b[1]);
        pr_next[2] = $signed(in_a[2]) * $signed(in_b[0]);
        pr_next[3] = $signed(in_a[0]) * $signed(in_b[2]);
        pr_next[4] = $signed(in_a[0]) * $signed(in_b[1]);
        pr_next[5] = $signed(in_a[1]) * $signed(in_b[0]);
    end

    always_comb
    begin
        c_next[0] = (PW+1)'(pr_reg[0]) - (PW+1)'(pr_reg[1]);
        c_next[1] = (PW+1)'(pr_reg[2]) - (PW+1)'(pr_reg[3]);
        c_next[2] = (PW+1)'(pr_reg[4]) - (PW+1)'(pr_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            c_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg     <= pr_next;
        p_side_reg <= in_side;
        c_reg      <= c_next;
        c_side_reg <= p_side_reg;
    end

    assign out_valid = c_valid_reg;
    assign out_vec   = c_reg;
    assign out_side  = c_side_reg;

endmodule

[rtl/rmo_norm.sv]
// ----------------------------------------------------------------------------
// rmo_norm
// Pipelined 3-vector normalizer: range shift, sum of squares, one square
// root step per stage and one quotient bit per stage, result in Q2.(W-2).
// ----------------------------------------------------------------------------
module rmo_norm #(
    parameter int IW = 16,
    parameter int W  = 16,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0][IW-1:0]   in_vec,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [2:0][W-1:0]    out_vec,
    output logic                 out_zero,
    output logic [SW-1:0]        out_side
);

    import rmo_pkg::*;

    localparam int F   = W - 2;
    localparam int PW  = $clog2(IW);
    localparam int SHW = $clog2(IW + 32);
    localparam int NW  = MAG_W + F + 1;
    localparam int NQ  = ISQRT_STEPS;
    localparam logic [63:0] LOW31 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [F:0]  ONE   = (F+1)'(1) << F;

    // stage A: magnitudes
    logic                 a_valid_reg;
    logic [2:0][IW-1:0]   a_mag_reg;
    logic [2:0][IW-1:0]   a_mag_next;
    logic [2:0]           a_neg_reg;
    logic [SW-1:0]        a_side_reg;

    // stage B: maximum
    logic                 b_valid_reg;
    logic [2:0][IW-1:0]   b_mag_reg;
    logic [2:0]           b_neg_reg;
    logic [IW-1:0]        b_m_reg;
    logic [IW-1:0]        b_m_next;
    logic [SW-1:0]        b_side_reg;

    // stage C: shift amount
    logic                 c_valid_reg;
    logic [2:0][IW-1:0]   c_mag_reg;
    logic [2:0]           c_neg_reg;
    logic                 c_zero_reg;
    logic                 c_rdir_reg;
    logic                 c_rdir_next;
    logic [SHW-1:0]       c_sh_reg;
    logic [SHW-1:0]       c_sh_next;
    logic [SW-1:0]        c_side_reg;

    // stage D: shifted magnitudes
    logic                 d_valid_reg;
    logic [2:0][MAG_W-1:0] d_a_reg;
    logic [2:0][MAG_W-1:0] d_a_next;
    logic [2:0]           d_neg_reg;
    logic                 d_zero_reg;
    logic [SW-1:0]        d_side_reg;

    // stage E: squares
    logic                 e_valid_reg;
    logic [2:0][SUM_W-1:0] e_sq_reg;
    logic [2:0][SUM_W-1:0] e_sq_next;
    logic [2:0][MAG_W-1:0] e_a_reg;
    logic [2:0]           e_neg_reg;
    logic                 e_zero_reg;
    logic [SW-1:0]        e_side_reg;

    // square root stages, index 0 is the sum register
    logic                  iv_reg   [0:NQ];
    logic [SUM_W-1:0]      ix_reg   [0:NQ];
    logic [SUM_W-1:0]      ir_reg   [0:NQ];
    logic [2:0][MAG_W-1:0] ia_reg   [0:NQ];
    logic [2:0]            ineg_reg [0:NQ];
    logic                  iz_reg   [0:NQ];
    logic [SW-1:0]         is_reg   [0:NQ];

    // divide stages, index 0 is the numerator register
    logic                  dv_reg   [0:F+1];
    logic [2:0][NW-1:0]    drem_reg [0:F+1];
    logic [2:0][F:0]       dq_reg   [0:F+1];
    logic [MAG_W-1:0]      dn_reg   [0:F+1];
    logic [2:0]            dneg_reg [0:F+1];
    logic                  dz_reg   [0:F+1];
    logic [SW-1:0]         ds_reg   [0:F+1];
    logic [2:0][NW-1:0]    g_num_next;

    // output stage
    logic                  o_valid_reg;
    logic [2:0][W-1:0]     o_vec_reg;
    logic [2:0][W-1:0]     o_vec_next;
    logic                  o_zero_reg;
    logic [SW-1:0]         o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = in_vec[i][IW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
    end

    always_comb
    begin
        b_m_next = a_mag_reg[0];
        if (a_mag_reg[1] > b_m_next)
        begin
            b_m_next = a_mag_reg[1];
        end
        if (a_mag_reg[2] > b_m_next)
        begin
            b_m_next = a_mag_reg[2];
        end
    end

    always_comb
    begin
        logic [PW-1:0] p;
        logic          extra;
        int            pi;
        p = '0;
        for (int j = 0; j < IW; j++)
        begin
            if (b_m_reg[j])
            begin
                p = PW'(j);
            end
        end
        pi          = int'(p);
        extra       = 1'b0;
        c_rdir_next = 1'b0;
        if (pi >= 31)
        begin
            extra       = ((b_m_reg >> (pi - 31)) & IW'(LOW31)) != '0;
            c_rdir_next = 1'b1;
            c_sh_next   = SHW'(pi - 31 + int'(extra));
        end
        else
        begin
            c_sh_next = SHW'(30 - pi);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (c_rdir_reg)
            begin
                d_a_next[i] = MAG_W'(c_mag_reg[i] >> c_sh_reg);
            end
            else
            begin
                d_a_next[i] = MAG_W'(c_mag_reg[i]) << c_sh_reg;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_sq_next[i] = d_a_reg[i] * d_a_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            iv_reg[0]   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            iv_reg[0]   <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg   <= a_mag_next;
        for (int i = 0; i < 3; i++)
        begin
            a_neg_reg[i] <= in_vec[i][IW-1];
        end
        a_side_reg  <= in_side;

        b_mag_reg   <= a_mag_reg;
        b_neg_reg   <= a_neg_reg;
        b_m_reg     <= b_m_next;
        b_side_reg  <= a_side_reg;

        c_mag_reg   <= b_mag_reg;
        c_neg_reg   <= b_neg_reg;
        c_zero_reg  <= (b_m_reg == '0);
        c_rdir_reg  <= c_rdir_next;
        c_sh_reg    <= c_sh_next;
        c_side_reg  <= b_side_reg;

        d_a_reg     <= d_a_next;
        d_neg_reg   <= c_neg_reg;
        d_zero_reg  <= c_zero_reg;
        d_side_reg  <= c_side_reg;

        e_sq_reg    <= e_sq_next;
        e_a_reg     <= d_a_reg;
        e_neg_reg   <= d_neg_reg;
        e_zero_reg  <= d_zero_reg;
        e_side_reg  <= d_side_reg;

        ix_reg[0]   <= e_sq_reg[0] + e_sq_reg[1] + e_sq_reg[2];
        ir_reg[0]   <= '0;
        ia_reg[0]   <= e_a_reg;
        ineg_reg[0] <= e_neg_reg;
        iz_reg[0]   <= e_zero_reg;
        is_reg[0]   <= e_side_reg;
    end

    for (genvar k = 0; k < NQ; k++)
    begin : g_isqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
        logic [SUM_W-1:0] t;
        logic             take;

        assign t    = ir_reg[k] + BIT;
        assign take = ix_reg[k] >= t;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                iv_reg[k+1] <= 1'b0;
            end
            else
            begin
                iv_reg[k+1] <= iv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            ix_reg[k+1]   <= take ? (ix_reg[k] - t) : ix_reg[k];
            ir_reg[k+1]   <= take ? ((ir_reg[k] >> 1) + BIT) : (ir_reg[k] >> 1);
            ia_reg[k+1]   <= ia_reg[k];
            ineg_reg[k+1] <= ineg_reg[k];
            iz_reg[k+1]   <= iz_reg[k];
            is_reg[k+1]   <= is_reg[k];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_num_next[i] = (NW'(ia_reg[NQ][i]) << F) + NW'(ir_reg[NQ][MAG_W-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= iv_reg[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0] <= g_num_next;
        dq_reg[0]   <= '0;
        dn_reg[0]   <= ir_reg[NQ][MAG_W-1:0];
        dneg_reg[0] <= ineg_reg[NQ];
        dz_reg[0]   <= iz_reg[NQ];
        ds_reg[0]   <= is_reg[NQ];
    end

    for (genvar j = 0; j <= F; j++)
    begin : g_div
        logic [NW-1:0]     d;
        logic [2:0][NW-1:0] rem_next;
        logic [2:0][F:0]   q_next;

        assign d = NW'(dn_reg[j]) << (F - j);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = drem_reg[j][i];
                q_next[i]   = dq_reg[j][i];
                if (drem_reg[j][i] >= d)
                begin
                    rem_next[i]      = drem_reg[j][i] - d;
                    q_next[i][F - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            drem_reg[j+1] <= rem_next;
            dq_reg[j+1]   <= q_next;
            dn_reg[j+1]   <= dn_reg[j];
            dneg_reg[j+1] <= dneg_reg[j];
            dz_reg[j+1]   <= dz_reg[j];
            ds_reg[j+1]   <= ds_reg[j];
        end
    end

    always_comb
    begin
        logic [F:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dq_reg[F+1][i] > ONE) ? ONE : dq_reg[F+1][i];
            if (dz_reg[F+1])
            begin
                o_vec_next[i] = '0;
            end
            else if (dneg_reg[F+1][i])
            begin
                o_vec_next[i] = -W'(qc);
            end
            else
            begin
                o_vec_next[i] = W'(qc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= dv_reg[F+1];
        end
    end

    always_ff @(posedge clk)
    begin
        o_vec_reg  <= o_vec_next;
        o_zero_reg <= dz_reg[F+1];
        o_side_reg <= ds_reg[F+1];
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_zero  = o_zero_reg;
    assign out_side  = o_side_reg;

endmodule

[rtl/rotation_matrix_orthonormalize_core.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_orthonormalize_core
// Orthonormalizes the left and up rows of a Q2.14 rotation block: normalized
// up, out = norm(left x up), left = norm(up x out).
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+----------------------------------
//  command  | start, busy, item         | beat taken when start && !busy
//  result   | done, result              | one-cycle strobe, no back-pressure
//
// One beat enters per cycle; busy stays low. Each beat passes through the three
// normalizers, each with 32 square-root stages and 15 quotient stages, and the
// two cross products.
// Reset clears all valid bits; beats in flight are dropped.
// ----------------------------------------------------------------------------
module rotation_matrix_orthonormalize_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rmo_pkg::item_t   item,
    output logic             done,
    output rmo_pkg::result_t result
);

    import rmo_pkg::*;

    localparam int W = COMPONENT_WIDTH;

    logic                    n1_valid;
    logic [2:0][W-1:0]       n1_vec;
    logic                    n1_zero;
    logic [3*W-1:0]          n1_side;

    logic                    x1_valid;
    logic [2:0][CROSS_W-1:0] x1_vec;
    logic [3*W:0]            x1_side;

    logic                    n2_valid;
    logic [2:0][W-1:0]       n2_vec;
    logic                    n2_zero;
    logic [3*W:0]            n2_side;

    logic                    x2_valid;
    logic [2:0][CROSS_W-1:0] x2_vec;
    logic [6*W:0]            x2_side;

    logic                    n3_valid;
    logic [2:0][W-1:0]       n3_vec;
    logic                    n3_zero;
    logic [6*W:0]            n3_side;

    logic                    done_reg;
    result_t                 result_reg;
    result_t                 result_next;

    assign busy = 1'b0;

    rmo_norm #(.IW(W), .W(W), .SW(3*W)) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_vec    ({item.up_z, item.up_y, item.up_x}),
        .in_side   ({item.left_z, item.left_y, item.left_x}),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    rmo_cross #(.AW(W), .BW(W), .SW(3*W+1)) u_cross_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_valid),
        .in_a      (n1_side),
        .in_b      (n1_vec),
        .in_side   ({n1_vec, n1_zero}),
        .out_valid (x1_valid),
        .out_vec   (x1_vec),
        .out_side  (x1_side)
    );

    rmo_norm #(.IW(CROSS_W), .W(W), .SW(3*W+1)) u_norm_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x1_valid),
        .in_vec    (x1_vec),
        .in_side   (x1_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    rmo_cross #(.AW(W), .BW(W), .SW(6*W+1)) u_cross_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n2_valid),
        .in_a      (n2_side[3*W:1]),
        .in_b      (n2_vec),
        .in_side   ({n2_vec, n2_side[3*W:1], n2_side[0] | n2_zero}),
        .out_valid (x2_valid),
        .out_vec   (x2_vec),
        .out_side  (x2_side)
    );

    rmo_norm #(.IW(CROSS_W), .W(W), .SW(6*W+1)) u_norm_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x2_valid),
        .in_vec    (x2_vec),
        .in_side   (x2_side),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_zero  (n3_zero),
        .out_side  (n3_side)
    );

    always_comb
    begin
        result_next.new_left_x = n3_vec[0];
        result_next.new_left_y = n3_vec[1];
        result_next.new_left_z = n3_vec[2];
        result_next.new_up_x   = n3_side[W:1];
        result_next.new_up_y   = n3_side[2*W:W+1];
        result_next.new_up_z   = n3_side[3*W:2*W+1];
        result_next.out_x      = n3_side[4*W:3*W+1];
        result_next.out_y      = n3_side[5*W:4*W+1];
        result_next.out_z      = n3_side[6*W:5*W+1];
        result_next.degenerate = n3_side[0] | n3_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= n3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/rmo_checker.sv]
// ----------------------------------------------------------------------------
// rmo_checker
// Port-level checks of the orthonormalizer: fixed latency, unit range and
// zero-vector flagging.
// ----------------------------------------------------------------------------
module rmo_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input rmo_pkg::item_t   item,
    input logic             done,
    input rmo_pkg::result_t result
);

    import rmo_pkg::*;

    logic range_ok;
    logic up_zero;

    always_comb
    begin
        range_ok = 1'b1;
        if (result.new_left_x > 16384 || result.new_left_x < -16384 ||
            result.new_left_y > 16384 || result.new_left_y < -16384 ||
            result.new_left_z > 16384 || result.new_left_z < -16384 ||
            result.new_up_x > 16384 || result.new_up_x < -16384 ||
            result.new_up_y > 16384 || result.new_up_y < -16384 ||
            result.new_up_z > 16384 || result.new_up_z < -16384 ||
            result.out_x > 16384 || result.out_x < -16384 ||
            result.out_y > 16384 || result.out_y < -16384 ||
            result.out_z > 16384 || result.out_z < -16384)
        begin
            range_ok = 1'b0;
        end
    end

    assign up_zero = (item.up_x == '0) && (item.up_y == '0) && (item.up_z == '0);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result beat missing after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without matching command beat");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> range_ok)
        else $error("result component outside unit range");

    a_zero_up: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && up_zero |-> ##LATENCY (done && result.degenerate))
        else $error("zero up vector not flagged");

endmodule

bind rotation_matrix_orthonormalize_core rmo_checker u_rmo_checker (.*);
